@@ src/ale_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the array list engine: operation and status
// codes, field widths and the command broadcast to the entry cells.
// ----------------------------------------------------------------------------
package ale_pkg;

   localparam int DEPTH_DEF = 32;
   localparam int MAX_CAP   = 32;
   localparam int CAP_RST   = 32;

   localparam int MODE_W = 3;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 6;
   localparam int STAT_W = 2;

   typedef enum logic [MODE_W-1:0] {
      OP_WRITE_AT   = 3'd0,
      OP_APPEND     = 3'd1,
      OP_INSERT     = 3'd2,
      OP_POP        = 3'd3,
      OP_DELETE     = 3'd4,
      OP_REMOVE_ALL = 3'd5,
      OP_FIND       = 3'd6,
      OP_READ_AT    = 3'd7
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic                     apply;
      mode_type                 mode;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         idx;
      logic [CNT_W-1:0]         count;
      logic [CNT_W-1:0]         cnt_m1;
      logic [CNT_W-1:0]         cap_m1;
      logic [CNT_W-1:0]         rd_pos;
   } cmd_type;

endpackage
`default_nettype wire

@@ src/ale_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ale_req_if / ale_rsp_if
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
interface ale_req_if;
   logic                             valid;
   logic                             ready;
   logic [ale_pkg::MODE_W-1:0]       mode;
   logic signed [ale_pkg::DATA_W-1:0] value;
   logic [ale_pkg::IDX_W-1:0]        index;

   modport source (output valid, output mode, output value, output index, input ready);
   modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface ale_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ale_pkg::DATA_W-1:0] result_value;
   logic [ale_pkg::IDX_W-1:0]         found_index;
   logic                              found;
   logic [ale_pkg::STAT_W-1:0]        status;
   logic [ale_pkg::CNT_W-1:0]         length;
   logic                              empty_res;

   modport source (output valid, output result_value, output found_index, output found,
                   output status, output length, output empty_res, input ready);
   modport sink   (input valid, input result_value, input found_index, input found,
                   input status, input length, input empty_res, output ready);
endinterface
`default_nettype wire

@@ src/ale_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ale_cell
// One list entry. Applies the broadcast command at its own position, shifts
// with its neighbors and passes the find and read chains along the row.
// ----------------------------------------------------------------------------
module ale_cell #(
   parameter int POS = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ale_pkg::cmd_type                  cmd,
   input  wire logic signed [ale_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [ale_pkg::DATA_W-1:0] right_data,
   output      logic signed [ale_pkg::DATA_W-1:0] entry_out,
   input  wire logic                              hit_in,
   output      logic                              hit_out,
   input  wire logic [ale_pkg::IDX_W-1:0]         fidx_in,
   output      logic [ale_pkg::IDX_W-1:0]         fidx_out,
   input  wire logic signed [ale_pkg::DATA_W-1:0] rd_in,
   output      logic signed [ale_pkg::DATA_W-1:0] rd_out
);

   localparam bit ACTIVE = (POS < ale_pkg::MAX_CAP);
   localparam logic [ale_pkg::CNT_W-1:0] POS_V = ale_pkg::CNT_W'(POS);

   logic signed [ale_pkg::DATA_W-1:0] entry_ff;
   logic signed [ale_pkg::DATA_W-1:0] entry_in;
   logic                              match;
   logic                              first;

   assign entry_out = entry_ff;

   // match within the current length
   assign match    = ACTIVE && (POS_V < cmd.count) && (entry_ff == cmd.value);
   assign first    = match && !hit_in;
   assign hit_out  = hit_in | match;
   assign fidx_out = fidx_in | (first ? POS_V[ale_pkg::IDX_W-1:0] : '0);
   assign rd_out   = rd_in | ((ACTIVE && POS_V == cmd.rd_pos) ? entry_ff : '0);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.apply && ACTIVE) begin
         case (cmd.mode)
            ale_pkg::OP_WRITE_AT: begin
               if (POS_V == cmd.idx) entry_in = cmd.value;
            end
            ale_pkg::OP_APPEND: begin
               if (POS_V == cmd.count) entry_in = cmd.value;
            end
            ale_pkg::OP_INSERT: begin
               if (POS_V == cmd.idx) begin
                  entry_in = cmd.value;
               end else if (POS_V > cmd.idx && POS_V <= cmd.count) begin
                  entry_in = left_data;
               end
            end
            ale_pkg::OP_POP: begin
               if (POS_V == cmd.cnt_m1) entry_in = '0;
            end
            ale_pkg::OP_DELETE: begin
               if (POS_V >= cmd.idx && POS_V < cmd.cap_m1) begin
                  entry_in = right_data;
               end else if (POS_V == cmd.cap_m1) begin
                  entry_in = '0;
               end
            end
            ale_pkg::OP_REMOVE_ALL: begin
               if (match) entry_in = '0;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
`default_nettype wire

@@ src/array_list_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_engine_top
// Bounded ordered list of signed 32-bit words held in a row of entry cells.
// ----------------------------------------------------------------------------
// Each request is decoded against the current length and capacity, broadcast
// to every cell, and all cells shift, write, clear or compare at the same
// clock edge while the find and read chains ripple along the row into the
// result register. A new request is taken every cycle as long as the result
// register is free or its result is taken in that cycle. The store is zero
// after reset with no clearing pass; the capacity register resets to 32 and
// is used clamped to the smaller of DEPTH and MAX_CAP.
// ----------------------------------------------------------------------------
module array_list_engine_top #(
   parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ale_req_if.sink                          req_chan,
   ale_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic [ale_pkg::CNT_W-1:0]   csr_wr_data
);

   localparam int LIM = (DEPTH > ale_pkg::MAX_CAP) ? ale_pkg::MAX_CAP : DEPTH;
   localparam logic [ale_pkg::CNT_W-1:0] LIM_V = ale_pkg::CNT_W'(LIM);

   logic [ale_pkg::CNT_W-1:0] cap_ff;
   logic [ale_pkg::CNT_W-1:0] count_ff;
   logic [ale_pkg::CNT_W-1:0] count_in;
   logic [ale_pkg::CNT_W-1:0] cap_eff;
   logic [ale_pkg::CNT_W-1:0] cfg_eff;
   logic [ale_pkg::CNT_W-1:0] idx_w;

   logic                              rsp_valid_ff;
   logic signed [ale_pkg::DATA_W-1:0] rv_ff;
   logic [ale_pkg::IDX_W-1:0]         fidx_ff;
   logic                              fnd_ff;
   ale_pkg::status_type               st_ff;
   logic [ale_pkg::CNT_W-1:0]         len_ff;

   logic                accept;
   ale_pkg::mode_type   mode;
   ale_pkg::status_type st;
   ale_pkg::cmd_type    cmd;

   logic signed [ale_pkg::DATA_W-1:0] ent   [DEPTH];
   logic                              hit   [DEPTH+1];
   logic [ale_pkg::IDX_W-1:0]         fidx  [DEPTH+1];
   logic signed [ale_pkg::DATA_W-1:0] rd    [DEPTH+1];

   assign cap_eff = (cap_ff > LIM_V) ? LIM_V : cap_ff;
   assign cfg_eff = (csr_wr_data > LIM_V) ? LIM_V : csr_wr_data;
   assign idx_w   = {1'b0, req_chan.index};
   assign mode    = ale_pkg::mode_type'(req_chan.mode);

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // status and new length
   always_comb begin
      st       = ale_pkg::ST_OK;
      count_in = count_ff;
      case (mode)
         ale_pkg::OP_WRITE_AT: begin
            if (idx_w >= cap_eff) st = ale_pkg::ST_RANGE;
            else if (count_ff <= idx_w) count_in = idx_w + 1'b1;
         end
         ale_pkg::OP_APPEND: begin
            if (count_ff >= cap_eff) st = ale_pkg::ST_FULL;
            else count_in = count_ff + 1'b1;
         end
         ale_pkg::OP_INSERT: begin
            if (idx_w >= cap_eff) st = ale_pkg::ST_RANGE;
            else if (count_ff >= cap_eff) st = ale_pkg::ST_FULL;
            else if (idx_w > count_ff) count_in = idx_w + 1'b1;
            else count_in = count_ff + 1'b1;
         end
         ale_pkg::OP_POP: begin
            if (count_ff == '0) st = ale_pkg::ST_EMPTY;
            else count_in = count_ff - 1'b1;
         end
         ale_pkg::OP_DELETE: begin
            if (count_ff == '0) st = ale_pkg::ST_EMPTY;
            else if (idx_w >= count_ff) st = ale_pkg::ST_RANGE;
            else count_in = count_ff - 1'b1;
         end
         ale_pkg::OP_READ_AT: begin
            if (idx_w >= cap_eff) st = ale_pkg::ST_RANGE;
         end
         default: begin
            st = ale_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      cmd.apply  = accept && (st == ale_pkg::ST_OK);
      cmd.mode   = mode;
      cmd.value  = req_chan.value;
      cmd.idx    = idx_w;
      cmd.count  = count_ff;
      cmd.cnt_m1 = count_ff - 1'b1;
      cmd.cap_m1 = cap_eff - 1'b1;
      cmd.rd_pos = (mode == ale_pkg::OP_POP) ? (count_ff - 1'b1) : idx_w;
   end

   assign hit[0]  = 1'b0;
   assign fidx[0] = '0;
   assign rd[0]   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ale_pkg::DATA_W-1:0] left_d;
      logic signed [ale_pkg::DATA_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = ent[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = ent[i+1];
      end

      ale_cell #(
         .POS (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .entry_out  (ent[i]),
         .hit_in     (hit[i]),
         .hit_out    (hit[i+1]),
         .fidx_in    (fidx[i]),
         .fidx_out   (fidx[i+1]),
         .rd_in      (rd[i]),
         .rd_out     (rd[i+1])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= ale_pkg::CNT_W'(ale_pkg::CAP_RST);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
            if (count_ff > cfg_eff) count_ff <= cfg_eff;
         end else if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff   <= st;
         len_ff  <= count_in;
         fnd_ff  <= (mode == ale_pkg::OP_FIND) && hit[DEPTH];
         fidx_ff <= (mode == ale_pkg::OP_FIND) ? fidx[DEPTH] : '0;
         rv_ff   <= ((st == ale_pkg::ST_OK) &&
                     (mode == ale_pkg::OP_POP || mode == ale_pkg::OP_READ_AT)) ?
                    rd[DEPTH] : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rv_ff;
   assign rsp_chan.found_index  = fidx_ff;
   assign rsp_chan.found        = fnd_ff;
   assign rsp_chan.status       = st_ff;
   assign rsp_chan.length       = len_ff;
   assign rsp_chan.empty_res    = (len_ff == '0);

endmodule
`default_nettype wire

@@ bench/array_list_engine_checker.sv @@
// ----------------------------------------------------------------------------
// array_list_engine_checker
// Watches the request, result and register ports of the list engine. It keeps
// its own copy of the list and the capacity, works out the result of every
// accepted request, and compares each accepted result field by field with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module array_list_engine_checker (
   input  logic                      clock,
   input  logic                      reset,
   ale_req_if                        req_mon,
   ale_rsp_if                        rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [ale_pkg::CNT_W-1:0] csr_wr_data,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [ale_pkg::DATA_W-1:0] result_value;
      logic [ale_pkg::IDX_W-1:0]         found_index;
      logic                              found;
      ale_pkg::status_type               status;
      logic [ale_pkg::CNT_W-1:0]         length;
      logic                              empty_res;
   } list_result_type;

   list_result_type            results_owed[$];
   logic [ale_pkg::DATA_W-1:0] list_words[ale_pkg::MAX_CAP];
   int unsigned                list_len;
   logic [ale_pkg::CNT_W-1:0]  cap_reg;

   function automatic int unsigned usable_cap();
      return (cap_reg > ale_pkg::MAX_CAP) ? ale_pkg::MAX_CAP : cap_reg;
   endfunction

   function automatic list_result_type apply_op(ale_pkg::mode_type op,
                                                logic [ale_pkg::DATA_W-1:0] word,
                                                int unsigned pos);
      list_result_type res;
      int unsigned     cap;
      int              i;
      res  = '0;
      res.status = ale_pkg::ST_OK;
      cap  = usable_cap();
      case (op)
         ale_pkg::OP_WRITE_AT: begin
            if (pos >= cap) begin
               res.status = ale_pkg::ST_RANGE;
            end else begin
               list_words[pos] = word;
               if (list_len < pos + 1) list_len = pos + 1;
            end
         end
         ale_pkg::OP_APPEND: begin
            if (list_len >= cap) begin
               res.status = ale_pkg::ST_FULL;
            end else begin
               list_words[list_len] = word;
               list_len++;
            end
         end
         ale_pkg::OP_INSERT: begin
            if (pos >= cap) begin
               res.status = ale_pkg::ST_RANGE;
            end else if (list_len >= cap) begin
               res.status = ale_pkg::ST_FULL;
            end else begin
               for (i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
               list_words[pos] = word;
               if (pos > list_len) list_len = pos + 1;
               else list_len++;
            end
         end
         ale_pkg::OP_POP: begin
            if (list_len == 0) begin
               res.status = ale_pkg::ST_EMPTY;
            end else begin
               list_len--;
               res.result_value = list_words[list_len];
               list_words[list_len] = '0;
            end
         end
         ale_pkg::OP_DELETE: begin
            if (list_len == 0) begin
               res.status = ale_pkg::ST_EMPTY;
            end else if (pos >= list_len) begin
               res.status = ale_pkg::ST_RANGE;
            end else begin
               for (i = pos; i + 1 < int'(cap); i++) list_words[i] = list_words[i+1];
               list_words[cap-1] = '0;
               list_len--;
            end
         end
         ale_pkg::OP_REMOVE_ALL: begin
            for (i = 0; i < int'(list_len); i++)
               if (list_words[i] == word) list_words[i] = '0;
         end
         ale_pkg::OP_FIND: begin
            for (i = 0; i < int'(list_len); i++) begin
               if (list_words[i] == word && !res.found) begin
                  res.found       = 1'b1;
                  res.found_index = ale_pkg::IDX_W'(i);
               end
            end
         end
         default: begin
            if (pos >= cap) res.status = ale_pkg::ST_RANGE;
            else res.result_value = list_words[pos];
         end
      endcase
      res.length    = ale_pkg::CNT_W'(list_len);
      res.empty_res = (list_len == 0);
      return res;
   endfunction

   task automatic report_fail(string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_result(list_result_type got);
      list_result_type want;
      if (results_owed.size() == 0) begin
         report_fail("result with no request outstanding");
         return;
      end
      want = results_owed.pop_front();
      if (got.result_value !== want.result_value)
         report_fail($sformatf("result_value expected %0h got %0h",
                               want.result_value, got.result_value));
      if (got.found_index !== want.found_index)
         report_fail($sformatf("found_index expected %0d got %0d",
                               want.found_index, got.found_index));
      if (got.found !== want.found)
         report_fail($sformatf("found expected %0b got %0b", want.found, got.found));
      if (got.status !== want.status)
         report_fail($sformatf("status expected %s got %0d", want.status.name(),
                               got.status));
      if (got.length !== want.length)
         report_fail($sformatf("length expected %0d got %0d", want.length, got.length));
      if (got.empty_res !== want.empty_res)
         report_fail($sformatf("empty_res expected %0b got %0b",
                               want.empty_res, got.empty_res));
   endtask

   always @(posedge clock) begin
      list_result_type got;
      if (reset) begin
         foreach (list_words[k]) list_words[k] = '0;
         list_len = 0;
         cap_reg  = ale_pkg::CNT_W'(ale_pkg::CAP_RST);
         results_owed.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.result_value = rsp_mon.result_value;
            got.found_index  = rsp_mon.found_index;
            got.found        = rsp_mon.found;
            got.status       = ale_pkg::status_type'(rsp_mon.status);
            got.length       = rsp_mon.length;
            got.empty_res    = rsp_mon.empty_res;
            check_result(got);
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            results_owed.push_back(apply_op(ale_pkg::mode_type'(req_mon.mode),
                                            req_mon.value, 32'(req_mon.index)));
         if (csr_wr_en) begin
            cap_reg = csr_wr_data;
            if (list_len > usable_cap()) list_len = usable_cap();
         end
      end
      pending = results_owed.size();
   end

endmodule

@@ bench/array_list_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// array_list_engine_top_tb
// Drives the list engine with a short directed sequence covering empty, full,
// out of range and capacity corner cases, then with random operation mixes
// over several capacity settings. Both channels stall at random; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module array_list_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 150;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [ale_pkg::CNT_W-1:0] csr_wr_data;
   int                        fail_count;
   int                        pending;
   int                        cycles;
   int                        cap_now;
   bit                        no_gaps;
   bit                        hold_rsp;

   ale_req_if req_chan ();
   ale_rsp_if rsp_chan ();

   array_list_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   array_list_engine_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("array_list_engine_top verification failed");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int held;
      bit hold_done;
      hold_done = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            hold_done = 1;
         end else if (!no_gaps && $urandom_range(0, 99) < 19) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_req(ale_pkg::mode_type op, logic [ale_pkg::DATA_W-1:0] word,
                           int pos);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 19) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode  <= op;
      req_chan.value <= word;
      req_chan.index <= ale_pkg::IDX_W'(pos);
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic drain_list();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (pending == 0);
   endtask

   task automatic set_capacity(int c);
      drain_list();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ale_pkg::CNT_W'(c);
      cap_now = c;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [ale_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0;
         4, 5:    return ale_pkg::DATA_W'($urandom_range(1, 6));
         default: return $urandom;
      endcase
   endfunction

   function automatic ale_pkg::mode_type pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return ale_pkg::OP_APPEND;
      if (r < 34) return ale_pkg::OP_INSERT;
      if (r < 44) return ale_pkg::OP_WRITE_AT;
      if (r < 56) return ale_pkg::OP_POP;
      if (r < 68) return ale_pkg::OP_DELETE;
      if (r < 74) return ale_pkg::OP_REMOVE_ALL;
      if (r < 87) return ale_pkg::OP_FIND;
      return ale_pkg::OP_READ_AT;
   endfunction

   function automatic int pick_index();
      int top_pos;
      top_pos = (cap_now > ale_pkg::MAX_CAP) ? ale_pkg::MAX_CAP : cap_now;
      if (top_pos == 0 || $urandom_range(0, 3) == 0) return $urandom_range(0, 31);
      return $urandom_range(0, top_pos - 1);
   endfunction

   initial begin
      int caps[8];
      int n;
      caps           = '{32, 6, 1, 19, 32, 0, 63, 9};
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_chan.valid = 1'b0;
      req_chan.mode  = ale_pkg::OP_WRITE_AT;
      req_chan.value = '0;
      req_chan.index = '0;
      no_gaps  = 0;
      hold_rsp = 0;
      cap_now  = ale_pkg::CAP_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list corners
      send_req(ale_pkg::OP_READ_AT, 32'h0, 0);
      send_req(ale_pkg::OP_POP, 32'h0, 0);
      send_req(ale_pkg::OP_DELETE, 32'h0, 0);
      send_req(ale_pkg::OP_FIND, 32'h0, 0);
      send_req(ale_pkg::OP_APPEND, 32'h7fff_ffff, 0);
      send_req(ale_pkg::OP_APPEND, 32'h8000_0000, 0);
      send_req(ale_pkg::OP_INSERT, 32'hffff_ffff, 0);
      // insert and write past the length
      send_req(ale_pkg::OP_INSERT, 32'h5, 10);
      send_req(ale_pkg::OP_WRITE_AT, 32'h1234_5678, 31);
      send_req(ale_pkg::OP_APPEND, 32'h9, 0);
      send_req(ale_pkg::OP_INSERT, 32'h9, 3);
      send_req(ale_pkg::OP_FIND, 32'h8000_0000, 0);
      send_req(ale_pkg::OP_FIND, 32'h7, 0);
      send_req(ale_pkg::OP_REMOVE_ALL, 32'hffff_ffff, 0);
      send_req(ale_pkg::OP_DELETE, 32'h0, 31);
      send_req(ale_pkg::OP_DELETE, 32'h0, 31);
      send_req(ale_pkg::OP_READ_AT, 32'h0, 20);
      send_req(ale_pkg::OP_POP, 32'h0, 0);
      send_req(ale_pkg::OP_WRITE_AT, 32'h0, 4);
      // zero capacity clamps the length
      set_capacity(0);
      send_req(ale_pkg::OP_READ_AT, 32'h0, 0);
      send_req(ale_pkg::OP_APPEND, 32'h1, 0);
      send_req(ale_pkg::OP_INSERT, 32'h1, 0);
      send_req(ale_pkg::OP_POP, 32'h0, 0);
      set_capacity(40);
      send_req(ale_pkg::OP_WRITE_AT, 32'hdead_beef, 31);
      send_req(ale_pkg::OP_READ_AT, 32'h0, 31);

      for (int p = 0; p < 8; p++) begin
         set_capacity(caps[p]);
         n = (caps[p] == 0) ? 40 : 230;
         no_gaps = (p == 3);
         for (int k = 0; k < n; k++) begin
            if (p == 1 && k == 0) hold_rsp = 1;
            if (p == 4 && k == 100) drain_list();
            send_req(pick_mode(), pick_word(), pick_index());
         end
         no_gaps = 0;
      end

      drain_list();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("array_list_engine_top verification clean");
      end else begin
         $display("array_list_engine_top verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/ale_pkg.sv
src/ale_if.sv
src/ale_cell.sv
src/array_list_engine_top.sv
bench/array_list_engine_checker.sv
bench/array_list_engine_top_tb.sv
